@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers, clocked on clk with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every edge outside reset
`define PNO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define PNO_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PNO_ASSERT(lbl, prop, msg)
`define PNO_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

@@ design/pno_pkg.sv @@
// ---------------------------------------------------------------------------
// pno_pkg
// Shared types, codes and constants of the octave noise block.
// ---------------------------------------------------------------------------
package pno_pkg;

  localparam int TABLE_SIZE      = 256;
  localparam int TIDX_W          = 8;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int ONE_Q           = 1 << FRAC_BITS;
  localparam int MUL_W           = 24;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int AMP_W           = FRAC_BITS + 1;
  localparam int OUT_W           = 19;
  localparam int OUT_HI          = 3 * ONE_Q;

  // opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EVAL2 = 2'd1,
    OP_EVAL1 = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_OCTAVE_COUNT = 2'd0;
  localparam logic [1:0] CFG_PERSISTENCE  = 2'd1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] noise_value;
    logic                    result_kind;
  } out_item_t;

  typedef struct packed {
    logic [3:0]       octave_count;
    logic [AMP_W-1:0] persistence;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [TIDX_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [TIDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RCX, S_RCX1, S_RA, S_RA1, S_RB, S_RB1,
    S_RHAA, S_RHAB, S_RHBA, S_RHBB,
    S_F0, S_F1, S_F2, S_F3, S_F4,
    S_L0, S_L1, S_L2, S_L3, S_L4, S_L5,
    S_P0, S_P1, S_DGO, S_DWAIT
  } st_t;

endpackage

@@ design/pno_table_ram.sv @@
// ---------------------------------------------------------------------------
// pno_table_ram
// Permutation table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pno_table_ram
  import pno_pkg::*;
(
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [TABLE_SIZE];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

@@ design/pno_mul.sv @@
// ---------------------------------------------------------------------------
// pno_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module pno_mul
  import pno_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

@@ design/pno_divider.sv @@
// ---------------------------------------------------------------------------
// pno_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pno_divider
  import pno_pkg::*;
#(
  parameter int DVD_W = 39,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  // one restoring step
  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = diff[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(DVD_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/pno_core.sv @@
// ---------------------------------------------------------------------------
// pno_core
// Sequencer: table walk, fade and blend on the shared multiplier, octave sum.
// ---------------------------------------------------------------------------
module pno_core
  import pno_pkg::*;
#(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  input  cfg_t      cfg,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int TOT_W = AMP_W + $clog2(MAX_OCTAVES);
  localparam int SUM_W = 36 + $clog2(MAX_OCTAVES);
  localparam int SAT_W = SUM_W + 1;
  localparam logic signed [MUL_W-1:0] K_ONE = MUL_W'(ONE_Q);
  localparam logic signed [MUL_W-1:0] K_15  = MUL_W'(15 * ONE_Q);
  localparam logic signed [MUL_W-1:0] K_10  = MUL_W'(10 * ONE_Q);
  localparam logic signed [SAT_W-1:0] K_HI  = SAT_W'(OUT_HI);
  localparam logic signed [PROD_W-1:0] K_RND = PROD_W'(ONE_Q / 2);

  st_t state_r, state_nxt;

  ram_req_t ram_req;
  logic [7:0] rdata;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic             div_start, div_done;
  logic [SUM_W-1:0] dividend, quo;

  logic              mode1d_r, fsel_r, neg_r;
  logic [23:0]       sx_r, sy_r;
  logic [7:0]        a_r, b_r, aa_r, ab_r, ba_r, bb_r;
  logic [7:0]        h_aa_r, h_ab_r, h_ba_r, h_bb_r;
  logic signed [MUL_W-1:0] c_r, l0_r;
  logic [AMP_W-1:0]  u_r, v_r, amp_r, per_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [TOT_W-1:0]  tot_r;
  logic [OCT_W-1:0]  oct_r, lim_r, oct_inc;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [7:0]        cx, cy;
  logic [15:0]       fx, fy, tsel;
  logic signed [17:0] fx18, fy18, fxm1, fym1;
  logic signed [MUL_W-1:0] t_s, six_t, mq, g00, g10, g01, g11, g0, g1, u_s, v_s, amp_s;
  logic signed [PROD_W-1:0] rnd_w;
  logic [AMP_W-1:0]  fade_clamped, per_clamped;
  logic [OCT_W-1:0]  lim_clamped;
  logic [SUM_W-1:0]  mag;
  logic signed [SAT_W-1:0] res2d, res1d;

  // eight-way gradient: +-u +-2v
  function automatic logic signed [MUL_W-1:0] grad2(input logic [7:0] h,
                                                    input logic signed [17:0] x,
                                                    input logic signed [17:0] y);
    logic signed [MUL_W-1:0] u, v, r;
    u = h[2] ? MUL_W'(y) : MUL_W'(x);
    v = h[2] ? MUL_W'(x) : MUL_W'(y);
    r = (h[0] ? -u : u) + (h[1] ? -(v <<< 1) : (v <<< 1));
    return r;
  endfunction

  // clamp to the output range
  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SAT_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > K_HI) r = OUT_W'(K_HI);
    else if (v < -K_HI) r = OUT_W'(-K_HI);
    else r = v[OUT_W-1:0];
    return r;
  endfunction

  pno_table_ram u_ram (.clk(clk), .req(ram_req), .rdata(rdata));

  pno_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));

  pno_divider #(.DVD_W(SUM_W), .DVS_W(TOT_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dividend),
    .divisor(tot_r), .done(div_done), .quotient(quo)
  );

  // coordinate fields and fixed-point helpers
  always_comb begin
    cx    = sx_r[23:16];
    cy    = sy_r[23:16];
    fx    = sx_r[15:0];
    fy    = sy_r[15:0];
    fx18  = $signed({2'b00, fx});
    fy18  = $signed({2'b00, fy});
    fxm1  = fx18 - 18'sd65536;
    fym1  = fy18 - 18'sd65536;
    tsel  = fsel_r ? fy : fx;
    t_s   = $signed({8'b0, tsel});
    six_t = (t_s <<< 2) + (t_s <<< 1);
    rnd_w = prod_r + K_RND;
    mq    = rnd_w[MUL_W+FRAC_BITS-1:FRAC_BITS];
    u_s   = $signed({7'b0, u_r});
    v_s   = $signed({7'b0, v_r});
    amp_s = $signed({7'b0, amp_r});
    g00   = grad2(h_aa_r, fx18, fy18);
    g10   = grad2(h_ba_r, fxm1, fy18);
    g01   = grad2(h_ab_r, fx18, fym1);
    g11   = grad2(h_bb_r, fxm1, fym1);
    g0    = h_aa_r[0] ? -MUL_W'(fx18) : MUL_W'(fx18);
    g1    = h_ba_r[0] ? -MUL_W'(fxm1) : MUL_W'(fxm1);
    if (mq < 0) fade_clamped = '0;
    else if (mq > K_ONE) fade_clamped = AMP_W'(ONE_Q);
    else fade_clamped = mq[AMP_W-1:0];
    per_clamped = (cfg.persistence > AMP_W'(ONE_Q)) ? AMP_W'(ONE_Q) : cfg.persistence;
    if (cfg.octave_count == 4'd0) lim_clamped = OCT_W'(1);
    else if (int'(cfg.octave_count) > MAX_OCTAVES) lim_clamped = OCT_W'(MAX_OCTAVES);
    else lim_clamped = OCT_W'(cfg.octave_count);
    oct_inc  = oct_r + 1'b1;
    mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    dividend = mag + SUM_W'(tot_r >> 1);
    res2d    = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    res1d    = {{(SAT_W-MUL_W){mq[MUL_W-1]}}, mq} + SAT_W'(g0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && (in_data.opcode == OP_EVAL2 || in_data.opcode == OP_EVAL1)) begin
          state_nxt = S_RCX;
        end
      end
      S_RCX:  state_nxt = S_RCX1;
      S_RCX1: state_nxt = mode1d_r ? S_F0 : S_RA;
      S_RA:   state_nxt = S_RA1;
      S_RA1:  state_nxt = S_RB;
      S_RB:   state_nxt = S_RB1;
      S_RB1:  state_nxt = S_RHAA;
      S_RHAA: state_nxt = S_RHAB;
      S_RHAB: state_nxt = S_RHBA;
      S_RHBA: state_nxt = S_RHBB;
      S_RHBB: state_nxt = S_F0;
      S_F0:   state_nxt = S_F1;
      S_F1:   state_nxt = S_F2;
      S_F2:   state_nxt = S_F3;
      S_F3:   state_nxt = S_F4;
      S_F4: begin
        if (mode1d_r) state_nxt = S_P0;
        else if (!fsel_r) state_nxt = S_F0;
        else state_nxt = S_L0;
      end
      S_L0:   state_nxt = S_L1;
      S_L1:   state_nxt = S_L2;
      S_L2:   state_nxt = S_L3;
      S_L3:   state_nxt = S_L4;
      S_L4:   state_nxt = S_L5;
      S_L5:   state_nxt = (oct_inc == lim_r) ? S_DGO : S_RCX;
      S_P0:   state_nxt = S_P1;
      S_P1:   state_nxt = S_IDLE;
      S_DGO:  state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // table port, multiplier operands, divider launch
  always_comb begin
    ram_req.we    = (state_r == S_IDLE) && start && (in_data.opcode == OP_LOAD);
    ram_req.waddr = in_data.table_index;
    ram_req.wdata = in_data.table_value;
    ram_req.raddr = cx;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    case (state_r)
      S_RCX1: ram_req.raddr = cx + 8'd1;
      S_RA:   ram_req.raddr = a_r;
      S_RA1:  ram_req.raddr = a_r + 8'd1;
      S_RB:   ram_req.raddr = b_r;
      S_RB1:  ram_req.raddr = b_r + 8'd1;
      S_RHAA: ram_req.raddr = aa_r;
      S_RHAB: ram_req.raddr = ab_r;
      S_RHBA: ram_req.raddr = ba_r;
      S_RHBB: ram_req.raddr = bb_r;
      S_F0: begin
        mul_a = t_s;
        mul_b = t_s;
      end
      S_F1: begin
        mul_a = mq;
        mul_b = t_s;
      end
      S_F2: begin
        mul_a = six_t - K_15;
        mul_b = t_s;
      end
      S_F3: begin
        mul_a = c_r;
        mul_b = mq + K_10;
      end
      S_L0: begin
        mul_a = u_s;
        mul_b = g10 - g00;
      end
      S_L1: begin
        mul_a = u_s;
        mul_b = g11 - g01;
      end
      S_L2: begin
        mul_a = v_s;
        mul_b = g01 + mq - l0_r;
      end
      S_L3: begin
        mul_a = l0_r + mq;
        mul_b = amp_s;
      end
      S_L4: begin
        mul_a = amp_s;
        mul_b = $signed({7'b0, per_r});
      end
      S_P0: begin
        mul_a = u_s;
        mul_b = g1 - g0;
      end
      S_DGO:  div_start = 1'b1;
      default: ;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_P1) || (state_r == S_DWAIT && div_done);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          sx_r     <= in_data.coord_x[23:0];
          sy_r     <= in_data.coord_y[23:0];
          mode1d_r <= (in_data.opcode == OP_EVAL1);
          fsel_r   <= 1'b0;
          amp_r    <= AMP_W'(ONE_Q);
          per_r    <= per_clamped;
          sum_r    <= '0;
          tot_r    <= '0;
          oct_r    <= '0;
          lim_r    <= lim_clamped;
        end
      end
      S_RCX1: begin
        a_r    <= rdata + cy;
        h_aa_r <= rdata;
      end
      S_RA:   b_r    <= rdata + cy;
      S_RA1:  aa_r   <= rdata;
      S_RB:   ab_r   <= rdata;
      S_RB1:  ba_r   <= rdata;
      S_RHAA: bb_r   <= rdata;
      S_RHAB: h_aa_r <= rdata;
      S_RHBA: h_ab_r <= rdata;
      S_RHBB: h_ba_r <= rdata;
      S_F0: begin
        if (!fsel_r) begin
          if (mode1d_r) h_ba_r <= rdata;
          else h_bb_r <= rdata;
        end
      end
      S_F2: c_r <= mq;
      S_F4: begin
        if (fsel_r) v_r <= fade_clamped;
        else u_r <= fade_clamped;
        fsel_r <= ~fsel_r;
      end
      S_L1: l0_r <= g00 + mq;
      S_L4: begin
        sum_r <= sum_r + $signed(prod_r[SUM_W-1:0]);
        tot_r <= tot_r + TOT_W'(amp_r);
      end
      S_L5: begin
        amp_r  <= mq[AMP_W-1:0];
        oct_r  <= oct_inc;
        sx_r   <= {sx_r[22:0], 1'b0};
        sy_r   <= {sy_r[22:0], 1'b0};
        fsel_r <= 1'b0;
      end
      S_DGO: neg_r <= sum_r[SUM_W-1];
      S_P1: begin
        out_data_r.noise_value <= sat(res1d);
        out_data_r.result_kind <= 1'b1;
      end
      S_DWAIT: begin
        if (div_done) begin
          out_data_r.noise_value <= sat(res2d);
          out_data_r.result_kind <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/perlin_octave_noise_top.sv @@
// ---------------------------------------------------------------------------
// perlin_octave_noise_top
// Fixed-point improved Perlin noise: 2D fractal octaves and 1D noise.
//
//   channel  ports                          transfer
//   input    start, busy, in_data           start high while busy low
//   result   out_valid, out_data            out_valid high, one cycle
//   config   cfg_valid, cfg_ready, cfg_*    cfg_valid and cfg_ready high
//
// A load writes the table from idle without going busy. A 2D evaluate
// makes ten table reads and thirteen multiplies per octave on one read
// port and one multiplier, then divides the octave sum by the summed
// amplitudes. The result appears in the cycle after the last step.
// Reset clears control only; the table is undefined until loaded.
// The receiver cannot stall; results are never held.
// ---------------------------------------------------------------------------
module perlin_octave_noise_top
  import pno_pkg::*;
#(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [AMP_W-1:0] cfg_data
);

`include "assert_macros.svh"

  logic [3:0]       octave_count_r;
  logic [AMP_W-1:0] persistence_r;
  cfg_t             cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= 4'd4;
      persistence_r  <= AMP_W'(ONE_Q / 2);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_OCTAVE_COUNT) octave_count_r <= cfg_data[3:0];
      else if (cfg_index == CFG_PERSISTENCE) persistence_r <= cfg_data;
    end
  end

  assign cfg_ready        = 1'b1;
  assign cfg.octave_count = octave_count_r;
  assign cfg.persistence  = persistence_r;

  pno_core #(.MAX_OCTAVES(MAX_OCTAVES)) u_core (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .cfg(cfg),
    .busy(busy), .out_valid(out_valid), .out_data(out_data)
  );

  // checks
  `PNO_ASSERT(a_eval_goes_busy, start && !busy && (in_data.opcode == OP_EVAL2 || in_data.opcode == OP_EVAL1) |=> busy, "evaluate accepted but core not busy")
  `PNO_ASSERT(a_result_after_work, out_valid |-> $past(busy), "result without preceding work")
  `PNO_ASSERT(a_load_no_result, start && !busy && in_data.opcode == OP_LOAD |=> !out_valid, "load produced a result")
  `PNO_ASSERT_NEVER(a_no_result_while_busy, out_valid && busy, "result strobe while busy")

endmodule
